### rtl/irpfe_pkg.sv
// ----------------------------------------------------------------------------
// irpfe_pkg
// Shared types and constants of the infrared pulse frame encoder.
// ----------------------------------------------------------------------------
package irpfe_pkg;

  localparam int unsigned PULSE_W  = 16;
  localparam int unsigned SPACE_W  = 20;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PULSE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_PULSE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_REPEAT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDR   = 3'd7;

  // Reset values
  localparam logic [PULSE_W-1:0] RST_BIT_PULSE     = 16'd560;
  localparam logic [PULSE_W-1:0] RST_ZERO_SPACE    = 16'd560;
  localparam logic [PULSE_W-1:0] RST_ONE_SPACE     = 16'd1680;
  localparam logic [PULSE_W-1:0] RST_HEADER_PULSE  = 16'd4500;
  localparam logic [PULSE_W-1:0] RST_HEADER_SPACE  = 16'd4500;
  localparam logic [SPACE_W-1:0] RST_REPEAT_PERIOD = 20'd110000;

  typedef struct packed {
    logic [PULSE_W-1:0] bit_pulse_us;
    logic [PULSE_W-1:0] zero_space_us;
    logic [PULSE_W-1:0] one_space_us;
    logic [PULSE_W-1:0] header_pulse_us;
    logic [PULSE_W-1:0] header_space_us;
    logic [SPACE_W-1:0] repeat_period_us;
    logic               short_repeat;
    logic [ADDR_W-1:0]  device_address;
  } cfg_t;

  // Control of the shared frame-length accumulator
  typedef struct packed {
    logic               load;
    logic               add;
    logic [PULSE_W-1:0] opa;
    logic [PULSE_W-1:0] opb;
  } acc_ctrl_t;

endpackage

### rtl/irpfe_cfg.sv
// ----------------------------------------------------------------------------
// irpfe_cfg
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module irpfe_cfg
  import irpfe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_pulse_us     <= RST_BIT_PULSE;
      cfg.zero_space_us    <= RST_ZERO_SPACE;
      cfg.one_space_us     <= RST_ONE_SPACE;
      cfg.header_pulse_us  <= RST_HEADER_PULSE;
      cfg.header_space_us  <= RST_HEADER_SPACE;
      cfg.repeat_period_us <= RST_REPEAT_PERIOD;
      cfg.short_repeat     <= 1'b0;
      cfg.device_address   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BIT_PULSE:     cfg.bit_pulse_us     <= cfg_data[PULSE_W-1:0];
        REG_ZERO_SPACE:    cfg.zero_space_us    <= cfg_data[PULSE_W-1:0];
        REG_ONE_SPACE:     cfg.one_space_us     <= cfg_data[PULSE_W-1:0];
        REG_HEADER_PULSE:  cfg.header_pulse_us  <= cfg_data[PULSE_W-1:0];
        REG_HEADER_SPACE:  cfg.header_space_us  <= cfg_data[PULSE_W-1:0];
        REG_REPEAT_PERIOD: cfg.repeat_period_us <= cfg_data[SPACE_W-1:0];
        REG_SHORT_REPEAT:  cfg.short_repeat     <= cfg_data[0];
        REG_DEVICE_ADDR:   cfg.device_address   <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/irpfe_accum.sv
// ----------------------------------------------------------------------------
// irpfe_accum
// Shared frame-length accumulator and trailer padding subtractor.
// ----------------------------------------------------------------------------
module irpfe_accum
  import irpfe_pkg::*;
#(
  parameter int unsigned TOTAL_W = 24
) (
  input  logic               clk,
  input  acc_ctrl_t          ctrl,
  input  logic [SPACE_W-1:0] period,
  output logic [SPACE_W-1:0] gap
);

  logic [TOTAL_W-1:0] acc;
  logic [TOTAL_W-1:0] period_ext;
  logic [TOTAL_W-1:0] diff;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= TOTAL_W'(ctrl.opa);
    end else if (ctrl.add) begin
      acc <= acc + TOTAL_W'(ctrl.opa) + TOTAL_W'(ctrl.opb);
    end
  end

  // The padding is always below the period, so it fits the space field.
  assign period_ext = TOTAL_W'(period);
  assign diff       = period_ext - acc;
  assign gap        = (acc < period_ext) ? diff[SPACE_W-1:0] : '0;

endmodule

### rtl/irpfe_seq.sv
// ----------------------------------------------------------------------------
// irpfe_seq
// Frame sequencer: walks header, data bits and trailer, one pair a cycle.
// ----------------------------------------------------------------------------
module irpfe_seq
  import irpfe_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = 16,
  parameter int unsigned COMMAND_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [CODE_W-1:0]  command_code,
  input  logic               is_repeat,
  input  cfg_t               cfg,
  input  logic [SPACE_W-1:0] gap,
  output acc_ctrl_t          acc_ctrl,
  output logic               result_valid,
  output logic [PULSE_W-1:0] pulse_us,
  output logic [SPACE_W-1:0] space_us,
  output logic               last
);

  localparam int unsigned NBITS = ADDRESS_BITS + 2 * COMMAND_BITS;
  localparam int unsigned CNT_W = $clog2(NBITS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_HEADER = 2'd1;
  localparam logic [1:0] S_BITS   = 2'd2;
  localparam logic [1:0] S_TRAIL  = 2'd3;

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [CNT_W-1:0]        count;
  logic [NBITS-1:0]        frame;
  logic [COMMAND_BITS-1:0] cmd_ext;
  logic [ADDRESS_BITS-1:0] addr_ext;
  logic                    accept;
  logic                    use_short;
  logic [PULSE_W-1:0]      bit_space;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign use_short = cfg.short_repeat && is_repeat;
  assign cmd_ext   = COMMAND_BITS'(command_code);
  assign addr_ext  = ADDRESS_BITS'(cfg.device_address);
  assign bit_space = frame[0] ? cfg.one_space_us : cfg.zero_space_us;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_HEADER;
      S_HEADER: state_next = S_BITS;
      S_BITS:   if (count == CNT_W'(1)) state_next = S_TRAIL;
      S_TRAIL:  state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // The trailer mark is preloaded so that only the padding is left at the end.
  always_comb begin
    acc_ctrl      = '0;
    acc_ctrl.opa  = cfg.bit_pulse_us;
    acc_ctrl.opb  = bit_space;
    unique case (state)
      S_IDLE: acc_ctrl.load = accept;
      S_HEADER: begin
        acc_ctrl.add = 1'b1;
        acc_ctrl.opa = cfg.header_pulse_us;
        acc_ctrl.opb = cfg.header_space_us;
      end
      S_BITS:  acc_ctrl.add = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state != S_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (use_short) begin
            frame <= NBITS'(1);
            count <= CNT_W'(1);
          end else begin
            frame <= {~cmd_ext, cmd_ext, addr_ext};
            count <= CNT_W'(NBITS);
          end
        end
      end
      S_HEADER: begin
        pulse_us <= cfg.header_pulse_us;
        space_us <= SPACE_W'(cfg.header_space_us);
        last     <= 1'b0;
      end
      S_BITS: begin
        pulse_us <= cfg.bit_pulse_us;
        space_us <= SPACE_W'(bit_space);
        last     <= 1'b0;
        frame    <= frame >> 1;
        count    <= count - CNT_W'(1);
      end
      S_TRAIL: begin
        pulse_us <= cfg.bit_pulse_us;
        space_us <= gap;
        last     <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### rtl/ir_pulse_frame_encoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_frame_encoder
// Turns one transmission request into the mark/space pairs of one frame.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  request   start, busy                command_code, is_repeat
//  result    result_valid (strobe)      pulse_us, space_us, last
//  config    cfg_valid, cfg_ready       cfg_index, cfg_data
//
// A transaction is accepted when start is high and busy is low. The first
// pair, the header, is registered in the header state, and one pair follows
// per cycle: ADDRESS_BITS + 2*COMMAND_BITS + 2 pairs for a standard frame
// (34 by default), three for a short repeat. busy drops while the trailer
// pair is on the ports, so the next request can be taken at the edge that
// takes the trailer; no request is taken while a frame is in progress. The
// pair rate is set by the sequencer stepping one bit a cycle through the
// shared accumulator.
// Reset is synchronous and restores the register defaults; results cannot be
// stalled.
// ----------------------------------------------------------------------------
module ir_pulse_frame_encoder
  import irpfe_pkg::*;
#(
  parameter int unsigned ADDRESS_BITS = 16,
  parameter int unsigned COMMAND_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [CODE_W-1:0]     command_code,
  input  logic                  is_repeat,
  output logic                  result_valid,
  output logic [PULSE_W-1:0]    pulse_us,
  output logic [SPACE_W-1:0]    space_us,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Room for every pair at full scale plus the trailer mark.
  localparam int unsigned TOTAL_W =
    PULSE_W + 1 + $clog2(ADDRESS_BITS + 2 * COMMAND_BITS + 3);

  cfg_t               cfg;
  acc_ctrl_t          acc_ctrl;
  logic [SPACE_W-1:0] gap;

  irpfe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  irpfe_accum #(
    .TOTAL_W (TOTAL_W)
  ) u_accum (
    .clk    (clk),
    .ctrl   (acc_ctrl),
    .period (cfg.repeat_period_us),
    .gap    (gap)
  );

  irpfe_seq #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .COMMAND_BITS (COMMAND_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command_code (command_code),
    .is_repeat    (is_repeat),
    .cfg          (cfg),
    .gap          (gap),
    .acc_ctrl     (acc_ctrl),
    .result_valid (result_valid),
    .pulse_us     (pulse_us),
    .space_us     (space_us),
    .last         (last)
  );

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the infrared pulse frame encoder. A table of
// directed requests and register writes covers reset values, the extreme
// timings, padding that floors at zero and short repeat frames. Random phases
// with fresh register settings follow. Every mark/space pair on the result
// strobe is compared with the frame predicted for the accepted request.
// ----------------------------------------------------------------------------
module tb_top;
  import irpfe_pkg::*;

  localparam int unsigned ADDR_BITS   = 16;
  localparam int unsigned CMD_BITS    = 8;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned N_PHASES    = 6;
  localparam int unsigned PHASE_ITEMS = 25;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse;
    logic [SPACE_W-1:0] space;
    logic               ends;
  } pair_t;

  typedef enum logic {ROW_WRITE, ROW_SEND} row_kind_t;

  // n_pairs of zero means the row is checked against the predictor only.
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [CODE_W-1:0]     cmd;
    logic                  rep;
    logic [5:0]            n_pairs;
    logic [SPACE_W-1:0]    trail;
  } stim_row_t;

  localparam int unsigned N_ROWS = 39;

  stim_row_t directed_rows [0:N_ROWS-1] = '{
    '{ROW_SEND,  '0, '0, 8'h00, 1'b0, 6'd34, 20'd55640},
    '{ROW_SEND,  '0, '0, 8'hFF, 1'b0, 6'd34, 20'd55640},
    '{ROW_SEND,  '0, '0, 8'hA5, 1'b1, 6'd34, 20'd55640},
    '{ROW_WRITE, REG_SHORT_REPEAT, 20'hFFFFF, '0, '0, '0, '0},
    '{ROW_SEND,  '0, '0, 8'h3C, 1'b1, 6'd3,  20'd98200},
    '{ROW_SEND,  '0, '0, 8'h3C, 1'b0, 6'd34, 20'd55640},
    '{ROW_WRITE, REG_DEVICE_ADDR, 20'hFFFFF, '0, '0, '0, '0},
    '{ROW_SEND,  '0, '0, 8'h00, 1'b0, 6'd34, 20'd37720},
    '{ROW_WRITE, REG_REPEAT_PERIOD, 20'h00000, '0, '0, '0, '0},
    '{ROW_SEND,  '0, '0, 8'h81, 1'b0, 6'd34, 20'd0},
    '{ROW_SEND,  '0, '0, 8'h81, 1'b1, 6'd3,  20'd0},
    '{ROW_WRITE, REG_BIT_PULSE, 20'hFFFFF, '0, '0, '0, '0},
    '{ROW_WRITE, REG_ZERO_SPACE, 20'hFFFFF, '0, '0, '0, '0},
    '{ROW_WRITE, REG_ONE_SPACE, 20'hFFFFF, '0, '0, '0, '0},
    '{ROW_WRITE, REG_HEADER_PULSE, 20'hFFFFF, '0, '0, '0, '0},
    '{ROW_WRITE, REG_HEADER_SPACE, 20'hFFFFF, '0, '0, '0, '0},
    '{ROW_WRITE, REG_REPEAT_PERIOD, 20'hFFFFF, '0, '0, '0, '0},
    '{ROW_SEND,  '0, '0, 8'h55, 1'b0, 6'd34, 20'd0},
    '{ROW_SEND,  '0, '0, 8'hAA, 1'b1, 6'd3,  20'd720900},
    '{ROW_WRITE, REG_BIT_PULSE, 20'hF0000, '0, '0, '0, '0},
    '{ROW_WRITE, REG_ZERO_SPACE, 20'hF0000, '0, '0, '0, '0},
    '{ROW_WRITE, REG_ONE_SPACE, 20'hF0000, '0, '0, '0, '0},
    '{ROW_WRITE, REG_HEADER_PULSE, 20'hF0000, '0, '0, '0, '0},
    '{ROW_WRITE, REG_HEADER_SPACE, 20'hF0000, '0, '0, '0, '0},
    '{ROW_WRITE, REG_DEVICE_ADDR, 20'hF0000, '0, '0, '0, '0},
    '{ROW_WRITE, REG_SHORT_REPEAT, 20'hFFFFE, '0, '0, '0, '0},
    '{ROW_SEND,  '0, '0, 8'hFF, 1'b0, 6'd34, 20'd1048575},
    '{ROW_SEND,  '0, '0, 8'h00, 1'b1, 6'd34, 20'd1048575},
    '{ROW_WRITE, REG_BIT_PULSE, 20'd560, '0, '0, '0, '0},
    '{ROW_WRITE, REG_ZERO_SPACE, 20'd560, '0, '0, '0, '0},
    '{ROW_WRITE, REG_ONE_SPACE, 20'd1680, '0, '0, '0, '0},
    '{ROW_WRITE, REG_HEADER_PULSE, 20'd4500, '0, '0, '0, '0},
    '{ROW_WRITE, REG_HEADER_SPACE, 20'd4500, '0, '0, '0, '0},
    '{ROW_WRITE, REG_REPEAT_PERIOD, 20'd110000, '0, '0, '0, '0},
    '{ROW_WRITE, REG_SHORT_REPEAT, 20'h00001, '0, '0, '0, '0},
    '{ROW_WRITE, REG_DEVICE_ADDR, 20'h01234, '0, '0, '0, '0},
    '{ROW_SEND,  '0, '0, 8'h12, 1'b0, 6'd0, 20'd0},
    '{ROW_SEND,  '0, '0, 8'hED, 1'b1, 6'd0, 20'd0},
    '{ROW_SEND,  '0, '0, 8'h7E, 1'b0, 6'd0, 20'd0}
  };

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [CODE_W-1:0]     command_code;
  logic                  is_repeat;
  logic                  result_valid;
  logic [PULSE_W-1:0]    pulse_us;
  logic [SPACE_W-1:0]    space_us;
  logic                  last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfg_t  enc_cfg;
  pair_t pairs_due[$];
  int    n_fail = 0;
  bit    idle_on;

  ir_pulse_frame_encoder #(
    .ADDRESS_BITS(ADDR_BITS),
    .COMMAND_BITS(CMD_BITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command_code(command_code),
    .is_repeat   (is_repeat),
    .result_valid(result_valid),
    .pulse_us    (pulse_us),
    .space_us    (space_us),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void reset_timings();
    enc_cfg.bit_pulse_us     = RST_BIT_PULSE;
    enc_cfg.zero_space_us    = RST_ZERO_SPACE;
    enc_cfg.one_space_us     = RST_ONE_SPACE;
    enc_cfg.header_pulse_us  = RST_HEADER_PULSE;
    enc_cfg.header_space_us  = RST_HEADER_SPACE;
    enc_cfg.repeat_period_us = RST_REPEAT_PERIOD;
    enc_cfg.short_repeat     = 1'b0;
    enc_cfg.device_address   = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_BIT_PULSE:     enc_cfg.bit_pulse_us     = data[PULSE_W-1:0];
      REG_ZERO_SPACE:    enc_cfg.zero_space_us    = data[PULSE_W-1:0];
      REG_ONE_SPACE:     enc_cfg.one_space_us     = data[PULSE_W-1:0];
      REG_HEADER_PULSE:  enc_cfg.header_pulse_us  = data[PULSE_W-1:0];
      REG_HEADER_SPACE:  enc_cfg.header_space_us  = data[PULSE_W-1:0];
      REG_REPEAT_PERIOD: enc_cfg.repeat_period_us = data[SPACE_W-1:0];
      REG_SHORT_REPEAT:  enc_cfg.short_repeat     = data[0];
      REG_DEVICE_ADDR:   enc_cfg.device_address   = data[ADDR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void push_bit_pair(input logic b, inout longint unsigned frame_len);
    pair_t p;
    p.pulse = enc_cfg.bit_pulse_us;
    p.space = b ? SPACE_W'(enc_cfg.one_space_us) : SPACE_W'(enc_cfg.zero_space_us);
    p.ends  = 1'b0;
    pairs_due.push_back(p);
    frame_len += p.pulse + p.space;
  endfunction

  // Queues the pairs of one frame and reports its length and trailer space.
  function automatic void predict_frame(input logic [CODE_W-1:0] cmd, input logic rep,
                                        output int n_pairs,
                                        output logic [SPACE_W-1:0] trail);
    longint unsigned frame_len;
    pair_t           p;
    int              first;
    first     = pairs_due.size();
    p.pulse   = enc_cfg.header_pulse_us;
    p.space   = SPACE_W'(enc_cfg.header_space_us);
    p.ends    = 1'b0;
    pairs_due.push_back(p);
    frame_len = p.pulse + p.space;
    if (enc_cfg.short_repeat && rep) begin
      push_bit_pair(1'b1, frame_len);
    end else begin
      // Bits beyond the register or port width go out as zero, inverted as one.
      for (int i = 0; i < ADDR_BITS; i++)
        push_bit_pair((i < ADDR_W) ? enc_cfg.device_address[i] : 1'b0, frame_len);
      for (int i = 0; i < CMD_BITS; i++)
        push_bit_pair((i < CODE_W) ? cmd[i] : 1'b0, frame_len);
      for (int i = 0; i < CMD_BITS; i++)
        push_bit_pair((i < CODE_W) ? ~cmd[i] : 1'b1, frame_len);
    end
    frame_len += enc_cfg.bit_pulse_us;
    if (frame_len < enc_cfg.repeat_period_us)
      trail = SPACE_W'(enc_cfg.repeat_period_us - frame_len);
    else
      trail = '0;
    p.pulse = enc_cfg.bit_pulse_us;
    p.space = trail;
    p.ends  = 1'b1;
    pairs_due.push_back(p);
    n_pairs = pairs_due.size() - first;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_reg_value(input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_DATA_W-1:0] v;
    // Upper bits are left random so that masking of narrow registers is exercised.
    v = CFG_DATA_W'($urandom);
    case (idx)
      REG_REPEAT_PERIOD: begin
        case ($urandom_range(0, 5))
          0:       v = '0;
          1:       v = '1;
          2:       ;
          default: v = CFG_DATA_W'($urandom_range(20000, 200000));
        endcase
      end
      REG_SHORT_REPEAT, REG_DEVICE_ADDR: ;
      default: begin
        case ($urandom_range(0, 5))
          0:       v[PULSE_W-1:0] = '0;
          1:       v[PULSE_W-1:0] = '1;
          2:       ;
          default: v[PULSE_W-1:0] = PULSE_W'($urandom_range(200, 5000));
        endcase
      end
    endcase
    return v;
  endfunction

  // All tasks below are entered and left just after a falling edge.
  task automatic send_request(input logic [CODE_W-1:0] cmd, input logic rep,
                              output int n_pairs, output logic [SPACE_W-1:0] trail);
    start        <= 1'b1;
    command_code <= cmd;
    is_repeat    <= rep;
    do @(posedge clk); while (busy);
    @(negedge clk);
    predict_frame(cmd, rep, n_pairs, trail);
  endtask

  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_frames();
    start <= 1'b0;
    while (pairs_due.size() != 0 || busy) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    if (idle_on && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 13)) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    apply_reg(idx, data);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    pair_t due;
    if (!rst && result_valid) begin
      if (pairs_due.size() == 0) begin
        $error("unexpected result: pulse_us %0d space_us %0d last %0b",
               pulse_us, space_us, last);
        n_fail++;
      end else begin
        due = pairs_due.pop_front();
        if (pulse_us !== due.pulse) begin
          $error("pulse_us: expected %0d, actual %0d", due.pulse, pulse_us);
          n_fail++;
        end
        if (space_us !== due.space) begin
          $error("space_us: expected %0d, actual %0d", due.space, space_us);
          n_fail++;
        end
        if (last !== due.ends) begin
          $error("last: expected %0b, actual %0b", due.ends, last);
          n_fail++;
        end
      end
    end
  end

  initial begin
    stim_row_t          row;
    int                 n_pairs;
    logic [SPACE_W-1:0] trail;
    rst          = 1'b1;
    start        = 1'b0;
    command_code = '0;
    is_repeat    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    idle_on      = 1'b1;
    reset_timings();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_WRITE) begin
        drain_frames();
        write_reg(row.idx, row.data);
      end else begin
        send_request(row.cmd, row.rep, n_pairs, trail);
        if (row.n_pairs != 0 && n_pairs != row.n_pairs) begin
          $error("frame length: expected %0d, actual %0d", row.n_pairs, n_pairs);
          n_fail++;
        end
        if (row.n_pairs != 0 && trail != row.trail) begin
          $error("trailer space_us: expected %0d, actual %0d", row.trail, trail);
          n_fail++;
        end
        if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 13));
      end
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      drain_frames();
      // The final phase runs with no gaps at all.
      idle_on = (phase < N_PHASES - 1);
      for (int r = 0; r < 8; r++)
        write_reg(CFG_IDX_W'(r), rand_reg_value(CFG_IDX_W'(r)));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_request(CODE_W'($urandom), 1'($urandom), n_pairs, trail);
        if (idle_on) begin
          if ($urandom_range(0, 14) == 0)
            drain_frames();
          else if ($urandom_range(0, 2) == 0)
            hold_off($urandom_range(1, 13));
        end
      end
    end

    drain_frames();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (n_fail == 0 && pairs_due.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
